### rtl/core/mlfd_pkg.sv
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants of the magic and length frame deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

  localparam int unsigned MAX_FRAME_LEN = 65536;
  localparam int LEN_W = 17;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [1:0] {
    PH_MAGIC  = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2,
    PH_CHECK  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA_OK    = 3'd0,
    ST_REG_OK     = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_BAD_SUM    = 3'd4,
    ST_UNKNOWN    = 3'd5,
    ST_SHORT      = 3'd6
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAGIC_WORD       = 3'd0,
    REG_MAX_LENGTH       = 3'd1,
    REG_CHECK_LENGTH     = 3'd2,
    REG_TRANSFER_COMMAND = 3'd3,
    REG_REGISTER_COMMAND = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]      magic_word;
    logic [LEN_W-1:0] max_length;
    logic [LEN_W-1:0] check_length;
    logic [15:0]      transfer_command;
    logic [15:0]      register_command;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    status_t          status;
    logic [LEN_W-1:0] count;
  } result_t;

endpackage

### rtl/core/mlfd_in_if.sv
// ----------------------------------------------------------------------------
// mlfd_in_if
// Byte input channel with valid and ready.
// ----------------------------------------------------------------------------
interface mlfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

### rtl/core/mlfd_out_if.sv
// ----------------------------------------------------------------------------
// mlfd_out_if
// Result channel carrying payload bytes and frame verdicts.
// ----------------------------------------------------------------------------
interface mlfd_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [2:0]  frame_status;
  logic [16:0] payload_count;

  modport source (output valid, output out_kind, output out_byte,
                  output frame_status, output payload_count, input ready);
  modport sink (input valid, input out_kind, input out_byte,
                input frame_status, input payload_count, output ready);
endinterface

### rtl/core/mlfd_cfg_if.sv
// ----------------------------------------------------------------------------
// mlfd_cfg_if
// Configuration write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mlfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/mlfd_parser.sv
// ----------------------------------------------------------------------------
// mlfd_parser
// Frame parsing state machine: consumes one byte per step and yields at
// most one result for it.
// ----------------------------------------------------------------------------
module mlfd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       in_byte,
  input  mlfd_pkg::cfg_t   cfg,
  output logic             emit,
  output mlfd_pkg::result_t result
);

  mlfd_pkg::phase_t              phase, phase_next;
  logic [mlfd_pkg::LEN_W-1:0]    field_count, field_count_next;
  logic [31:0]                   header_shift, header_shift_next;
  logic [mlfd_pkg::LEN_W-1:0]    frame_length, frame_length_next;
  logic [15:0]                   running_sum, running_sum_next;
  logic [15:0]                   command_word, command_word_next;

  logic [mlfd_pkg::LEN_W-1:0]    count_inc;
  logic [31:0]                   shifted;
  logic [mlfd_pkg::LEN_W-1:0]    cap;
  logic                          passing;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mlfd_pkg::PH_MAGIC;
      field_count  <= '0;
      header_shift <= '0;
      frame_length <= '0;
      running_sum  <= '0;
      command_word <= '0;
    end else if (step) begin
      phase        <= phase_next;
      field_count  <= field_count_next;
      header_shift <= header_shift_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
      command_word <= command_word_next;
    end
  end

  assign count_inc = field_count + mlfd_pkg::LEN_W'(1);
  assign shifted   = {header_shift[23:0], in_byte};
  assign cap       = (cfg.max_length > mlfd_pkg::LEN_W'(mlfd_pkg::MAX_FRAME_LEN)) ?
                     mlfd_pkg::LEN_W'(mlfd_pkg::MAX_FRAME_LEN) : cfg.max_length;
  assign passing   = (command_word == cfg.transfer_command) &&
                     (command_word != cfg.register_command) &&
                     (frame_length > mlfd_pkg::LEN_W'(2));

  always_comb begin
    phase_next        = phase;
    field_count_next  = count_inc;
    header_shift_next = shifted;
    frame_length_next = frame_length;
    running_sum_next  = running_sum;
    command_word_next = command_word;
    emit              = 1'b0;
    result            = '0;
    unique case (phase)
      mlfd_pkg::PH_MAGIC: begin
        if (count_inc >= mlfd_pkg::LEN_W'(2)) begin
          field_count_next  = '0;
          header_shift_next = '0;
          if (shifted[15:0] != cfg.magic_word) begin
            emit          = 1'b1;
            result.kind   = 1'b1;
            result.status = mlfd_pkg::ST_BAD_MAGIC;
          end else begin
            phase_next = mlfd_pkg::PH_LENGTH;
          end
        end
      end
      mlfd_pkg::PH_LENGTH: begin
        if (count_inc >= mlfd_pkg::LEN_W'(4)) begin
          field_count_next  = '0;
          header_shift_next = '0;
          if ((shifted == 32'd0) || (shifted > {15'd0, cap})) begin
            emit          = 1'b1;
            result.kind   = 1'b1;
            result.status = mlfd_pkg::ST_BAD_LENGTH;
            phase_next    = mlfd_pkg::PH_MAGIC;
          end else begin
            frame_length_next = shifted[mlfd_pkg::LEN_W-1:0];
            running_sum_next  = '0;
            command_word_next = '0;
            phase_next        = mlfd_pkg::PH_DATA;
          end
        end
      end
      mlfd_pkg::PH_DATA: begin
        header_shift_next = header_shift;
        if (field_count < cfg.check_length) begin
          running_sum_next = running_sum + {8'd0, in_byte};
        end
        if (field_count < mlfd_pkg::LEN_W'(2)) begin
          command_word_next = {command_word[7:0], in_byte};
        end else if (passing) begin
          emit        = 1'b1;
          result.data = in_byte;
        end
        if (count_inc >= frame_length) begin
          field_count_next  = '0;
          header_shift_next = '0;
          phase_next        = mlfd_pkg::PH_CHECK;
        end
      end
      mlfd_pkg::PH_CHECK: begin
        if (count_inc >= mlfd_pkg::LEN_W'(2)) begin
          field_count_next  = '0;
          header_shift_next = '0;
          phase_next        = mlfd_pkg::PH_MAGIC;
          emit              = 1'b1;
          result.kind       = 1'b1;
          result.count      = passing ? (frame_length - mlfd_pkg::LEN_W'(2)) : '0;
          if (shifted[15:0] != running_sum) begin
            result.status = mlfd_pkg::ST_BAD_SUM;
          end else if (frame_length <= mlfd_pkg::LEN_W'(2)) begin
            result.status = mlfd_pkg::ST_SHORT;
          end else if (command_word == cfg.register_command) begin
            result.status = mlfd_pkg::ST_REG_OK;
          end else if (command_word == cfg.transfer_command) begin
            result.status = mlfd_pkg::ST_DATA_OK;
          end else begin
            result.status = mlfd_pkg::ST_UNKNOWN;
          end
        end
      end
      default: begin
        phase_next = mlfd_pkg::PH_MAGIC;
      end
    endcase
  end

endmodule

### rtl/core/magic_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// magic_length_frame_deframer
// Parses magic and length prefixed frames from a byte stream, passes
// transfer payload bytes through and ends every frame with one verdict item.
// ----------------------------------------------------------------------------
// The block accepts one byte item in every cycle while the consumer takes
// results and offers at most one result item for it from the output register:
// the byte is held in an input register, and when the parser steps on it, it
// updates its counters and running sum and the result lands in an output
// register. The parser state loop is the only recurrence, so the rate stays at
// one item per cycle while the consumer takes results; payload bytes are passed
// on before the checksum is known, and the closing verdict item tells the
// consumer whether to keep them.
module magic_length_frame_deframer (
  input logic        clk,
  input logic        rst,
  mlfd_cfg_if.sink   cfg,
  mlfd_in_if.sink    ingress,
  mlfd_out_if.source egress
);

  mlfd_pkg::cfg_t    cfg_regs;
  logic              in_valid;
  logic [7:0]        in_data;
  logic              out_valid;
  mlfd_pkg::result_t out_data;
  logic              emit;
  mlfd_pkg::result_t result;
  logic              step;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.magic_word       <= 16'd0;
      cfg_regs.max_length       <= mlfd_pkg::LEN_W'(65536);
      cfg_regs.check_length     <= mlfd_pkg::LEN_W'(65536);
      cfg_regs.transfer_command <= 16'd0;
      cfg_regs.register_command <= 16'd1;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        mlfd_pkg::REG_MAGIC_WORD:       cfg_regs.magic_word       <= cfg.data[15:0];
        mlfd_pkg::REG_MAX_LENGTH:       cfg_regs.max_length       <= cfg.data;
        mlfd_pkg::REG_CHECK_LENGTH:     cfg_regs.check_length     <= cfg.data;
        mlfd_pkg::REG_TRANSFER_COMMAND: cfg_regs.transfer_command <= cfg.data[15:0];
        mlfd_pkg::REG_REGISTER_COMMAND: cfg_regs.register_command <= cfg.data[15:0];
        default: begin
        end
      endcase
    end
  end

  mlfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_data),
    .cfg     (cfg_regs),
    .emit    (emit),
    .result  (result)
  );

  assign step          = in_valid && (!emit || !out_valid || egress.ready);
  assign ingress.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (ingress.ready) begin
      in_valid <= ingress.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ingress.valid && ingress.ready) begin
      in_data <= ingress.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (egress.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_data <= result;
    end
  end

  assign egress.valid         = out_valid;
  assign egress.out_kind      = out_data.kind;
  assign egress.out_byte      = out_data.data;
  assign egress.frame_status  = out_data.status;
  assign egress.payload_count = out_data.count;

`ifndef ASSERT_OFF
  a_payload_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (egress.valid && !egress.out_kind) |->
      (egress.frame_status == mlfd_pkg::ST_DATA_OK && egress.payload_count == 17'd0))
    else $error("payload item carries status or count");

  a_verdict_byte_clear: assert property (@(posedge clk) disable iff (rst)
    (egress.valid && egress.out_kind) |-> (egress.out_byte == 8'd0))
    else $error("verdict item carries a byte value");

  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (rst)
    !ingress.ready |-> (egress.valid && !egress.ready))
    else $error("input stalled while the output could take an item");

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !egress.valid)
    else $error("result item offered straight after reset");
`endif

endmodule

### dv/magic_length_frame_deframer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// magic_length_frame_deframer_test
// Self-checking bench for the magic and length frame deframer. Byte streams of
// well-formed frames, corrupted frames and noise are driven under several
// register settings and idling patterns. Every byte accepted by the block is
// run through a predictor of the parser, and each result item is compared
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module magic_length_frame_deframer_test;

  logic clk;
  logic rst;

  mlfd_cfg_if cfg_ch ();
  mlfd_in_if  in_ch ();
  mlfd_out_if out_ch ();

  magic_length_frame_deframer u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .ingress (in_ch),
    .egress  (out_ch)
  );

  logic [7:0]        pending_bytes[$];
  mlfd_pkg::result_t expected_results[$];
  int unsigned       pushed_count;
  int unsigned       fail_count;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  logic              hold_start;
  int unsigned       hold_left;

  mlfd_pkg::cfg_t    cfg_shadow;
  mlfd_pkg::phase_t  prs_phase;
  int unsigned       prs_count;
  logic [31:0]       prs_shift;
  logic [16:0]       prs_len;
  logic [15:0]       prs_sum;
  logic [15:0]       prs_cmd;

  mlfd_pkg::result_t next_result;
  mlfd_pkg::result_t seen_result;
  mlfd_pkg::result_t oldest_result;

  function automatic logic [31:0] length_cap();
    if (cfg_shadow.max_length > mlfd_pkg::MAX_FRAME_LEN) begin
      return mlfd_pkg::MAX_FRAME_LEN;
    end
    return cfg_shadow.max_length;
  endfunction

  function automatic void begin_hunt();
    prs_phase = mlfd_pkg::PH_MAGIC;
    prs_count = 0;
    prs_shift = '0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output mlfd_pkg::result_t r);
    logic [15:0] rx;
    bit          passing;
    bit          emitted;
    r = '0;
    emitted = 1'b0;
    passing = (prs_cmd == cfg_shadow.transfer_command) &&
              (prs_cmd != cfg_shadow.register_command) && (prs_len > 2);
    case (prs_phase)
      mlfd_pkg::PH_MAGIC: begin
        prs_shift = {prs_shift[23:0], b};
        prs_count++;
        if (prs_count >= 2) begin
          rx = prs_shift[15:0];
          begin_hunt();
          if (rx != cfg_shadow.magic_word) begin
            r.kind = 1'b1;
            r.status = mlfd_pkg::ST_BAD_MAGIC;
            return 1'b1;
          end
          prs_phase = mlfd_pkg::PH_LENGTH;
        end
        return 1'b0;
      end
      mlfd_pkg::PH_LENGTH: begin
        prs_shift = {prs_shift[23:0], b};
        prs_count++;
        if (prs_count >= 4) begin
          if (prs_shift == 0 || prs_shift > length_cap()) begin
            begin_hunt();
            r.kind = 1'b1;
            r.status = mlfd_pkg::ST_BAD_LENGTH;
            return 1'b1;
          end
          prs_len = prs_shift[16:0];
          begin_hunt();
          prs_sum = '0;
          prs_cmd = '0;
          prs_phase = mlfd_pkg::PH_DATA;
        end
        return 1'b0;
      end
      mlfd_pkg::PH_DATA: begin
        if (prs_count < cfg_shadow.check_length) begin
          prs_sum = prs_sum + b;
        end
        if (prs_count < 2) begin
          prs_cmd = {prs_cmd[7:0], b};
        end else if (passing) begin
          r.data = b;
          emitted = 1'b1;
        end
        prs_count++;
        if (prs_count >= prs_len) begin
          prs_count = 0;
          prs_shift = '0;
          prs_phase = mlfd_pkg::PH_CHECK;
        end
        return emitted;
      end
      default: begin
        prs_shift = {prs_shift[23:0], b};
        prs_count++;
        if (prs_count >= 2) begin
          rx = prs_shift[15:0];
          r.kind = 1'b1;
          r.count = passing ? prs_len - 17'd2 : '0;
          if (rx != prs_sum) begin
            r.status = mlfd_pkg::ST_BAD_SUM;
          end else if (prs_len <= 2) begin
            r.status = mlfd_pkg::ST_SHORT;
          end else if (prs_cmd == cfg_shadow.register_command) begin
            r.status = mlfd_pkg::ST_REG_OK;
          end else if (prs_cmd == cfg_shadow.transfer_command) begin
            r.status = mlfd_pkg::ST_DATA_OK;
          end else begin
            r.status = mlfd_pkg::ST_UNKNOWN;
          end
          begin_hunt();
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.in_byte, next_result)) begin
          expected_results.push_back(next_result);
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= pending_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_result.kind = out_ch.out_kind;
        seen_result.data = out_ch.out_byte;
        seen_result.status = mlfd_pkg::status_t'(out_ch.frame_status);
        seen_result.count = out_ch.payload_count;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result kind %0d byte %02h status %0d count %0d",
                   $time, seen_result.kind, seen_result.data, seen_result.status,
                   seen_result.count);
        end else begin
          oldest_result = expected_results.pop_front();
          if (seen_result !== oldest_result) begin
            fail_count++;
            $display("%0t: mismatch, expected kind %0d byte %02h status %0d count %0d, %s",
                     $time, oldest_result.kind, oldest_result.data, oldest_result.status,
                     oldest_result.count,
                     $sformatf("got kind %0d byte %02h status %0d count %0d",
                               seen_result.kind, seen_result.data, seen_result.status,
                               seen_result.count));
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input mlfd_pkg::cfg_reg_t idx, input logic [16:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      mlfd_pkg::REG_MAGIC_WORD:       cfg_shadow.magic_word = value[15:0];
      mlfd_pkg::REG_MAX_LENGTH:       cfg_shadow.max_length = value;
      mlfd_pkg::REG_CHECK_LENGTH:     cfg_shadow.check_length = value;
      mlfd_pkg::REG_TRANSFER_COMMAND: cfg_shadow.transfer_command = value[15:0];
      mlfd_pkg::REG_REGISTER_COMMAND: cfg_shadow.register_command = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic push_word(input logic [15:0] w);
    pending_bytes.push_back(w[15:8]);
    pending_bytes.push_back(w[7:0]);
    pushed_count += 2;
  endtask

  task automatic push_frame(input logic [15:0] magic, input logic [31:0] len_field,
                            input logic [15:0] cmd, input bit corrupt_sum);
    logic [15:0] sum;
    logic [7:0]  b;
    push_word(magic);
    push_word(len_field[31:16]);
    push_word(len_field[15:0]);
    if (len_field == 0 || len_field > length_cap()) begin
      return;
    end
    sum = '0;
    for (int unsigned i = 0; i < len_field; i++) begin
      b = (i == 0) ? cmd[15:8] : (i == 1) ? cmd[7:0] : 8'($urandom);
      if (i < cfg_shadow.check_length) begin
        sum = sum + b;
      end
      pending_bytes.push_back(b);
      pushed_count++;
    end
    if (corrupt_sum) begin
      sum = sum ^ 16'($urandom_range(1, 65535));
    end
    push_word(sum);
  endtask

  task automatic random_traffic(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    int unsigned top;
    logic [15:0] cmd;
    logic [31:0] bad_len;
    start = pushed_count;
    while (pushed_count - start < target) begin
      pick = $urandom_range(99);
      top = length_cap();
      if (top > (($urandom_range(9) == 0) ? 200 : 16)) begin
        top = ($urandom_range(9) == 0) ? 200 : 16;
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4: cmd = cfg_shadow.transfer_command;
        5, 6:          cmd = cfg_shadow.register_command;
        default:       cmd = 16'($urandom);
      endcase
      if (pick < 80 && top == 0) begin
        push_frame(cfg_shadow.magic_word, 1, cmd, 1'b0);
      end else if (pick < 68) begin
        push_frame(cfg_shadow.magic_word, $urandom_range(1, top), cmd, 1'b0);
      end else if (pick < 80) begin
        push_frame(cfg_shadow.magic_word, $urandom_range(1, top), cmd, 1'b1);
      end else if (pick < 87) begin
        push_word(cfg_shadow.magic_word ^ 16'($urandom_range(1, 65535)));
      end else if (pick < 94) begin
        case ($urandom_range(2))
          0:       bad_len = 0;
          1:       bad_len = length_cap() + 1;
          default: bad_len = $urandom | 32'h0002_0000;
        endcase
        push_frame(cfg_shadow.magic_word, bad_len, cmd, 1'b0);
      end else begin
        repeat ($urandom_range(1, 3)) push_word(16'($urandom));
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    hold_start <= 1'b0;
    fail_count = 0;
    pushed_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_shadow.magic_word = 16'h0000;
    cfg_shadow.max_length = 17'd65536;
    cfg_shadow.check_length = 17'd65536;
    cfg_shadow.transfer_command = 16'h0000;
    cfg_shadow.register_command = 16'h0001;
    begin_hunt();
    prs_len = '0;
    prs_sum = '0;
    prs_cmd = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_idling(0, 0);
    push_frame(16'h0000, 3, 16'h0000, 1'b0);
    push_frame(16'h0000, 0, 16'h0000, 1'b0);
    push_frame(16'h0000, 65537, 16'h0000, 1'b0);
    push_frame(16'h0000, 4, 16'h0001, 1'b0);
    random_traffic(200);
    wait_quiet();

    write_reg(mlfd_pkg::REG_MAGIC_WORD, 17'h0A55A);
    write_reg(mlfd_pkg::REG_MAX_LENGTH, 17'd24);
    write_reg(mlfd_pkg::REG_CHECK_LENGTH, 17'd5);
    write_reg(mlfd_pkg::REG_TRANSFER_COMMAND, 17'h01234);
    write_reg(mlfd_pkg::REG_REGISTER_COMMAND, 17'h0BEEF);
    set_idling(78, 0);
    push_word(16'hA55B);
    push_frame(16'hA55A, 25, 16'h1234, 1'b0);
    push_frame(16'hA55A, 24, 16'h1234, 1'b0);
    push_frame(16'hA55A, 8, 16'h1234, 1'b1);
    push_frame(16'hA55A, 2, 16'hBEEF, 1'b0);
    push_frame(16'hA55A, 1, 16'h1234, 1'b0);
    push_frame(16'hA55A, 6, 16'h5555, 1'b0);
    push_frame(16'hA55A, 7, 16'hBEEF, 1'b0);
    random_traffic(200);
    wait_quiet();

    write_reg(mlfd_pkg::REG_MAGIC_WORD, 17'h0FFFF);
    write_reg(mlfd_pkg::REG_MAX_LENGTH, 17'd0);
    write_reg(mlfd_pkg::REG_CHECK_LENGTH, 17'd0);
    set_idling(0, 78);
    push_frame(16'hFFFF, 1, 16'hFFFF, 1'b0);
    push_frame(16'hFFFF, 65536, 16'hFFFF, 1'b0);
    random_traffic(40);
    wait_quiet();

    write_reg(mlfd_pkg::REG_MAX_LENGTH, 17'h1FFFF);
    write_reg(mlfd_pkg::REG_TRANSFER_COMMAND, 17'h0FFFF);
    write_reg(mlfd_pkg::REG_REGISTER_COMMAND, 17'h0FFFF);
    set_idling(22, 22);
    push_frame(16'hFFFF, 65537, 16'hFFFF, 1'b0);
    push_frame(16'hFFFF, 10, 16'hFFFF, 1'b0);
    push_frame(16'hFFFF, 10, 16'hFFFF, 1'b1);
    random_traffic(200);
    wait_quiet();

    write_reg(mlfd_pkg::REG_MAGIC_WORD, 17'h00000);
    write_reg(mlfd_pkg::REG_MAX_LENGTH, 17'd65536);
    write_reg(mlfd_pkg::REG_CHECK_LENGTH, 17'd1);
    write_reg(mlfd_pkg::REG_TRANSFER_COMMAND, 17'h000FF);
    write_reg(mlfd_pkg::REG_REGISTER_COMMAND, 17'h0FF00);
    set_idling(0, 0);
    random_traffic(200);
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    wait_quiet();

    write_reg(mlfd_pkg::REG_MAGIC_WORD, 17'($urandom_range(0, 65535)));
    write_reg(mlfd_pkg::REG_MAX_LENGTH, 17'($urandom_range(2, 64)));
    write_reg(mlfd_pkg::REG_CHECK_LENGTH, 17'($urandom_range(0, 64)));
    write_reg(mlfd_pkg::REG_TRANSFER_COMMAND, 17'($urandom_range(0, 65535)));
    write_reg(mlfd_pkg::REG_REGISTER_COMMAND, 17'($urandom_range(0, 65535)));
    case ($urandom_range(3))
      0:       set_idling(0, 0);
      1:       set_idling(78, 0);
      2:       set_idling(0, 78);
      default: set_idling(22, 22);
    endcase
    random_traffic(200);
    wait_quiet();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/mlfd_pkg.sv
rtl/core/mlfd_in_if.sv
rtl/core/mlfd_out_if.sv
rtl/core/mlfd_cfg_if.sv
rtl/core/mlfd_parser.sv
rtl/core/magic_length_frame_deframer.sv
dv/magic_length_frame_deframer_test.sv
